/* src/brh_pkg.sv */
`default_nettype none
package brh_pkg;

	localparam int CAT_COUNT = 5;
	localparam int CNT_W     = 32;
	localparam int LEN_W     = 48;
	localparam int KIND_W    = 3;
	localparam int SIDX_W    = 5;
	localparam int CAT_AW    = 3;
	localparam int ATAN_IW   = 5;
	localparam int ATAN_N    = 24;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// category slots, emitted kind is slot + 1
	localparam logic [CAT_AW-1:0] CAT_NORMAL = 3'd0;
	localparam logic [CAT_AW-1:0] CAT_HORZ   = 3'd1;
	localparam logic [CAT_AW-1:0] CAT_SURF   = 3'd2;
	localparam logic [CAT_AW-1:0] CAT_DUP    = 3'd3;
	localparam logic [CAT_AW-1:0] CAT_SPLAY  = 3'd4;

	localparam logic [KIND_W-1:0] KIND_SECTOR = 3'd0;

	// atan(2^-i) in 2^-32 turns
	localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage
`default_nettype wire

/* src/brh_sqrt.sv */
`default_nettype none
module brh_sqrt #(
	parameter int SQW = 52
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SQW-1:0]     radicand,
	output logic                    done,
	output logic [SQW/2:0]          root
);
	localparam int RW  = SQW / 2;
	localparam int RMW = RW + 2;
	localparam int CW  = $clog2(RW + 1);

	logic [SQW-1:0] rad_q;
	logic [RMW-1:0] rem_q;
	logic [RW-1:0]  root_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [RMW+1:0] rem_next;
	logic [RMW+1:0] trial;
	logic           fits;

	assign rem_next = {rem_q, rad_q[SQW-1 -: 2]};
	assign trial    = (RMW + 2)'({root_q, 2'b01});
	assign fits     = rem_next >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one result bit per cycle, two radicand bits brought down
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			root_q <= {root_q[RW-2:0], fits};
			rem_q  <= fits ? RMW'(rem_next - trial) : RMW'(rem_next);
		end
	end

	// round to nearest: up when remainder exceeds floor root
	assign done = done_q;
	assign root = (rem_q > RMW'(root_q)) ? ((RW + 1)'(root_q) + 1'b1) : (RW + 1)'(root_q);

endmodule
`default_nettype wire

/* src/brh_cordic.sv */
`default_nettype none
module brh_cordic #(
	parameter int DW = 25,
	parameter int AB = 16,
	parameter int PRESCALE = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [DW-1:0] east,
	input  wire logic signed [DW-1:0] north,
	output logic                      done,
	output logic [AB-1:0]             bearing
);
	localparam int CW = 64;
	localparam logic [31:0] RND = 32'd1 << (31 - AB);

	logic signed [CW-1:0] x_q, y_q;
	logic [AB-1:0]        acc_q;
	logic [brh_pkg::ATAN_IW-1:0] i_q;
	logic                 busy_q, done_q;

	logic signed [CW-1:0] x0, y0, xs, ys;
	logic [31:0]          stepw;
	logic [AB-1:0]        step;

	assign x0 = CW'(north) <<< PRESCALE;
	assign y0 = CW'(east) <<< PRESCALE;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign stepw = (brh_pkg::ATAN_TURN[i_q] + RND) >> (32 - AB);
	assign step  = stepw[AB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == brh_pkg::ATAN_IW'(AB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// southern half folded over, angle starts at half a turn
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x0[CW-1] ? -x0 : x0;
			y_q   <= x0[CW-1] ? -y0 : y0;
			acc_q <= x0[CW-1] ? AB'(1 << (AB - 1)) : '0;
		end else if (busy_q) begin
			if (!y_q[CW-1]) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				acc_q <= acc_q + step;
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				acc_q <= acc_q - step;
			end
		end
	end

	assign done    = done_q;
	assign bearing = acc_q;

endmodule
`default_nettype wire

/* src/bearing_rose_histogram_top.sv */
`default_nettype none
// channel  | dir | beat fields (lowest bit first)
// s_axis   | in  | tdata: pos_x, pos_y, pos_z; tuser: mode, is_surface, is_duplicate,
//          |     |   is_splay; tlast: end_of_data
// m_axis   | out | tdata: sector_index, item_count, length_total; tuser: entry_kind;
//          |     |   tlast: final_entry
// cfg      | in  | cfg_we/cfg_wdata: sectors_in_use
//
// a move beat without end_of_data leaves the sequencer idle; a line beat holds s_tready low
// from accept through three squares, two square roots and the category update, plus the
// horizontal update, the cordic bearing and two sector passes for a normal leg with
// horizontal extent; the square root and the cordic rotation are both iterative
// s_tready is high only while the sequencer is idle
// a summary emits n + 5 beats, one per cycle while m_tready holds high
// reset clears all counters, totals and the previous point at once
module bearing_rose_histogram_top #(
	parameter int MAX_SECTORS = 32,
	parameter int COORD_BITS  = 24,
	parameter int ANGLE_BITS  = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]    s_tdata,  // pos_x, pos_y, pos_z
	input  wire logic [3:0]                           s_tuser,  // mode, surface, dup, splay
	input  wire logic                                 s_tlast,  // end_of_data
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [87:0]                               m_tdata,  // sector_index, count, length
	output logic [2:0]                                m_tuser,  // entry_kind
	output logic                                      m_tlast,  // final_entry
	input  wire logic                                 cfg_we,
	input  wire logic [5:0]                           cfg_wdata // sectors_in_use
);
	localparam int CB       = COORD_BITS;
	localparam int DW       = CB + 1;             // coordinate difference
	localparam int SQW      = 2 * DW + 2;         // sum of three squares
	localparam int RTW      = SQW / 2 + 1;        // rounded root
	localparam int AB       = ANGLE_BITS;
	localparam int AW       = $clog2(MAX_SECTORS);
	localparam int PRESCALE = 58 - CB;
	localparam int LW       = brh_pkg::LEN_W;
	localparam int KW       = brh_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_RTH_GO, ST_RTH_WAIT, ST_RTF_GO, ST_RTF_WAIT,
		ST_CAT, ST_HORZ, ST_BRG_GO, ST_BRG_WAIT, ST_SEC_MUL, ST_SEC_ADD, ST_DUMP
	} state_t;

	state_t state_q;

	// configuration and effective sector count
	logic [5:0] cfg_q;
	logic [5:0] n_eff;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 6'd16;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end
	assign n_eff = (cfg_q == '0) ? 6'd1 :
	               (cfg_q > 6'(MAX_SECTORS)) ? 6'(MAX_SECTORS) : cfg_q;

	// input fields
	logic signed [CB-1:0] in_x, in_y, in_z;
	assign in_x = s_tdata[CB-1:0];
	assign in_y = s_tdata[2*CB-1:CB];
	assign in_z = s_tdata[3*CB-1:2*CB];

	logic signed [CB-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [DW-1:0] dx_q, dy_q, dz_q;
	logic                 surf_q, dup_q, splay_q, eod_q;

	// squares, one multiply a cycle
	logic [1:0]           sq_cnt_q;
	logic signed [DW-1:0] d_sel;
	logic [DW-1:0]        mag;
	logic [2*DW-1:0]      sq_prod_s1;
	logic [SQW-1:0]       hsq_q, fsq_q;

	assign d_sel = (sq_cnt_q == 2'd0) ? dx_q : (sq_cnt_q == 2'd1) ? dy_q : dz_q;
	assign mag   = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);

	// shared square root
	logic           rt_start, rt_done;
	logic [SQW-1:0] rt_in;
	logic [RTW-1:0] rt_root;
	logic [RTW-1:0] lh_q, l3_q;

	assign rt_start = (state_q == ST_RTH_GO) || (state_q == ST_RTF_GO);
	assign rt_in    = (state_q == ST_RTH_GO) ? hsq_q : fsq_q;

	brh_sqrt #(.SQW(SQW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(rt_start), .radicand(rt_in),
		.done(rt_done), .root(rt_root)
	);

	// bearing
	logic          cd_done;
	logic [AB-1:0] cd_bearing, b_q;

	brh_cordic #(.DW(DW), .AB(AB), .PRESCALE(PRESCALE)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_BRG_GO),
		.east(dx_q), .north(dy_q), .done(cd_done), .bearing(cd_bearing)
	);

	// sector binning: s = (n*b + half) >> AB, wrapped at n
	logic          pass_q;
	logic [AB-1:0] b_sel;
	logic [AB+6:0] sprod_s1;
	logic [6:0]    s_full;
	logic [5:0]    s_idx;

	assign b_sel  = pass_q ? (b_q + AB'(1 << (AB - 1))) : b_q;
	assign s_full = 7'(sprod_s1 >> AB);
	assign s_idx  = (s_full >= 7'(n_eff)) ? 6'd0 : 6'(s_full);

	// histogram storage
	logic [KW-1:0] sec_hits_q [MAX_SECTORS];
	logic [LW-1:0] sec_len_q  [MAX_SECTORS];
	logic [KW-1:0] cat_hits_q [brh_pkg::CAT_COUNT];
	logic [LW-1:0] cat_len_q  [brh_pkg::CAT_COUNT];

	logic [5:0]                dcnt_q;
	logic [5:0]                dcat;
	logic [AW-1:0]             sec_addr;
	logic [brh_pkg::CAT_AW-1:0] cat_addr, leg_cat;
	logic [KW-1:0]             sec_hits_rd, cat_hits_rd;
	logic [LW-1:0]             sec_len_rd, cat_len_rd;
	logic                      sec_we, cat_we, clr_all;
	logic [LW-1:0]             add_len;
	logic [KW-1:0]             sec_hits_nx, cat_hits_nx;
	logic [LW-1:0]             sec_len_nx, cat_len_nx;
	logic [LW:0]               sec_sum, cat_sum;
	logic                      out_free, dump_last;

	assign leg_cat = surf_q ? brh_pkg::CAT_SURF :
	                 dup_q ? brh_pkg::CAT_DUP :
	                 splay_q ? brh_pkg::CAT_SPLAY : brh_pkg::CAT_NORMAL;

	assign dcat     = dcnt_q - n_eff;
	assign sec_addr = (state_q == ST_DUMP) ? dcnt_q[AW-1:0] : s_idx[AW-1:0];
	assign cat_addr = (state_q == ST_DUMP) ? dcat[brh_pkg::CAT_AW-1:0] :
	                  (state_q == ST_HORZ) ? brh_pkg::CAT_HORZ : leg_cat;

	assign sec_hits_rd = sec_hits_q[sec_addr];
	assign sec_len_rd  = sec_len_q[sec_addr];
	assign cat_hits_rd = cat_hits_q[cat_addr];
	assign cat_len_rd  = cat_len_q[cat_addr];

	assign add_len = (state_q == ST_CAT) ? LW'(l3_q) : LW'(lh_q);
	assign sec_sum = {1'b0, sec_len_rd} + (LW + 1)'(lh_q);
	assign cat_sum = {1'b0, cat_len_rd} + (LW + 1)'(add_len);

	// saturating updates
	assign sec_hits_nx = (sec_hits_rd == brh_pkg::CNT_MAX) ? sec_hits_rd : sec_hits_rd + 1'b1;
	assign cat_hits_nx = (cat_hits_rd == brh_pkg::CNT_MAX) ? cat_hits_rd : cat_hits_rd + 1'b1;
	assign sec_len_nx  = sec_sum[LW] ? brh_pkg::LEN_MAX : sec_sum[LW-1:0];
	assign cat_len_nx  = cat_sum[LW] ? brh_pkg::LEN_MAX : cat_sum[LW-1:0];

	assign out_free  = !m_tvalid || m_tready;
	assign dump_last = dcnt_q == (n_eff + 6'd4);

	assign sec_we  = state_q == ST_SEC_ADD;
	assign cat_we  = (state_q == ST_CAT) || (state_q == ST_HORZ);
	assign clr_all = (state_q == ST_DUMP) && out_free && dump_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SECTORS; i++) begin
				sec_hits_q[i] <= '0;
				sec_len_q[i]  <= '0;
			end
			for (int i = 0; i < brh_pkg::CAT_COUNT; i++) begin
				cat_hits_q[i] <= '0;
				cat_len_q[i]  <= '0;
			end
		end else if (clr_all) begin
			for (int i = 0; i < MAX_SECTORS; i++) begin
				sec_hits_q[i] <= '0;
				sec_len_q[i]  <= '0;
			end
			for (int i = 0; i < brh_pkg::CAT_COUNT; i++) begin
				cat_hits_q[i] <= '0;
				cat_len_q[i]  <= '0;
			end
		end else begin
			if (sec_we) begin
				sec_hits_q[sec_addr] <= sec_hits_nx;
				sec_len_q[sec_addr]  <= sec_len_nx;
			end
			if (cat_we) begin
				cat_hits_q[cat_addr] <= cat_hits_nx;
				cat_len_q[cat_addr]  <= cat_len_nx;
			end
		end
	end

	// sequencer and output register
	logic [2:0]       out_kind_q;
	logic [4:0]       out_sidx_q;
	logic [KW-1:0]    out_cnt_q;
	logic [LW-1:0]    out_len_q;
	logic             out_last_q, out_valid_q;
	logic             in_beat;

	assign s_tready = state_q == ST_IDLE;
	assign in_beat  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			dcnt_q      <= '0;
			sq_cnt_q    <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a summary beat, else drop the one just taken
			if (state_q == ST_DUMP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						prev_x_q <= in_x;
						prev_y_q <= in_y;
						prev_z_q <= in_z;
						sq_cnt_q <= '0;
						if (s_tuser[0]) begin
							state_q <= ST_SQ;
						end else if (s_tlast) begin
							state_q <= ST_DUMP;
						end
					end
				end
				ST_SQ: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 2'd3) begin
						state_q <= ST_RTH_GO;
					end
				end
				ST_RTH_GO: state_q <= ST_RTH_WAIT;
				ST_RTH_WAIT: begin
					if (rt_done) begin
						state_q <= ST_RTF_GO;
					end
				end
				ST_RTF_GO: state_q <= ST_RTF_WAIT;
				ST_RTF_WAIT: begin
					if (rt_done) begin
						state_q <= ST_CAT;
					end
				end
				ST_CAT: begin
					if (leg_cat == brh_pkg::CAT_NORMAL && lh_q != '0) begin
						state_q <= ST_HORZ;
					end else begin
						state_q <= eod_q ? ST_DUMP : ST_IDLE;
					end
				end
				ST_HORZ: state_q <= ST_BRG_GO;
				ST_BRG_GO: state_q <= ST_BRG_WAIT;
				ST_BRG_WAIT: begin
					if (cd_done) begin
						pass_q  <= 1'b0;
						state_q <= ST_SEC_MUL;
					end
				end
				ST_SEC_MUL: state_q <= ST_SEC_ADD;
				ST_SEC_ADD: begin
					if (!pass_q) begin
						pass_q  <= 1'b1;
						state_q <= ST_SEC_MUL;
					end else begin
						state_q <= eod_q ? ST_DUMP : ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						out_last_q  <= dump_last;
						if (dcnt_q < n_eff) begin
							out_kind_q <= brh_pkg::KIND_SECTOR;
							out_sidx_q <= dcnt_q[4:0];
							out_cnt_q  <= sec_hits_rd;
							out_len_q  <= sec_len_rd;
						end else begin
							out_kind_q <= 3'(dcat) + 3'd1;
							out_sidx_q <= '0;
							out_cnt_q  <= cat_hits_rd;
							out_len_q  <= cat_len_rd;
						end
						if (dump_last) begin
							dcnt_q   <= '0;
							prev_x_q <= '0;
							prev_y_q <= '0;
							prev_z_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							dcnt_q <= dcnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_beat) begin
			dx_q    <= DW'(in_x) - DW'(prev_x_q);
			dy_q    <= DW'(in_y) - DW'(prev_y_q);
			dz_q    <= DW'(in_z) - DW'(prev_z_q);
			surf_q  <= s_tuser[1];
			dup_q   <= s_tuser[2];
			splay_q <= s_tuser[3];
			eod_q   <= s_tlast;
		end
		sq_prod_s1 <= mag * mag;
		if (state_q == ST_SQ) begin
			if (sq_cnt_q == 2'd1) hsq_q <= SQW'(sq_prod_s1);
			if (sq_cnt_q == 2'd2) hsq_q <= hsq_q + SQW'(sq_prod_s1);
			if (sq_cnt_q == 2'd3) fsq_q <= hsq_q + SQW'(sq_prod_s1);
		end
		if (state_q == ST_RTH_WAIT && rt_done) lh_q <= rt_root;
		if (state_q == ST_RTF_WAIT && rt_done) l3_q <= rt_root;
		if (state_q == ST_BRG_WAIT && cd_done) b_q <= cd_bearing;
		sprod_s1 <= (AB + 7)'(n_eff) * (AB + 7)'(b_sel) + (AB + 7)'(1 << (AB - 1));
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_len_q, out_cnt_q, out_sidx_q};

	// beats leave the output register only from a summary
	a_rise_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DUMP)
		else $error("result beat outside summary");

	a_dump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> dcnt_q <= n_eff + 6'd4)
		else $error("summary index past last entry");

	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		rt_done |-> (state_q == ST_RTH_WAIT || state_q == ST_RTF_WAIT))
		else $error("square root finished while not awaited");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cd_done |-> state_q == ST_BRG_WAIT)
		else $error("bearing finished while not awaited");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_all |=> cat_hits_q[brh_pkg::CAT_NORMAL] == '0 && prev_x_q == '0)
		else $error("state not cleared after summary");

endmodule
`default_nettype wire
